/* rtl/assert_macros.svh */
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge outside reset.
`define LDR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that cons holds in the cycle after ante.
`define LDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`else

`define LDR_ASSERT(label, clk, rst, prop, msg)
`define LDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/ldr_pkg.sv */
package ldr_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_item;
  } ldr_in_t;

  typedef struct packed {
    logic                      keep;
    logic signed [VALUE_W-1:0] kept_value;
    logic [COUNT_W-1:0]        distinct_count;
    logic                      overflow;
    logic                      list_end;
  } ldr_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic publish;
  } ldr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ldr_stat_t;

endpackage

/* rtl/list_duplicate_remover_top.sv */
// First-occurrence filter over lists of signed 32-bit values.
// Input channel: in_valid / in_stall / in_data (value, last_item). Output
// channel: out_valid / out_stall / out_data (keep, kept_value, distinct_count,
// overflow, list_end). An item moves at a rising edge with valid high and
// stall low. Every input item gives exactly one result.
// Each item is compared against the distinct values stored so far, one table
// entry per cycle from a single-port-read memory. From accept to result an
// item goes through these steps: accept, one read per stored entry (fewer
// when a match is found early), drain of the memory read, publish. One item
// is in work at a time; the next is taken once the controller is back in
// idle after the publish step.
// A new value is appended while the table has room; with the table full it is
// flagged overflow and not stored. The result of the last_item item carries
// the count including that item, then the table is emptied for the next list.
// The result sits in an output register: a new item is taken while an older
// result waits under out_stall; the block holds in the publish step only if
// the output register is still occupied. Reset empties the table at once (no
// clearing pass) and drops out_valid; in_stall is high while rst is high.
`include "assert_macros.svh"

module list_duplicate_remover_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ldr_pkg::ldr_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ldr_pkg::ldr_out_t out_data
);

  ldr_pkg::ldr_cmd_t  cmd;
  ldr_pkg::ldr_stat_t stat;

  ldr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ldr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // One item in work at a time
  `LDR_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall, "accepted item did not block the input")
  // A result appears only from a publish step
  `LDR_ASSERT(a_rise_from_publish, clk, rst, $rose(out_valid) |-> $past(cmd.publish), "result appeared without publish")
  // Overflow is only reported on a value that is kept
  `LDR_ASSERT(a_overflow_keeps, clk, rst, out_valid |-> (!out_data.overflow || out_data.keep), "overflow on a dropped item")

endmodule

/* rtl/ldr_ram.sv */
module ldr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/ldr_ctrl.sv */
module ldr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ldr_pkg::ldr_stat_t stat,
  output ldr_pkg::ldr_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  state_t state;

  // Take an item only while idle and out of reset
  assign in_stall = rst || (state != ST_IDLE);

  always_comb begin
    cmd.load    = (state == ST_IDLE) && in_valid && !rst;
    cmd.scan    = (state == ST_SCAN);
    cmd.publish = (state == ST_DECIDE) && stat.out_free;
  end

  // Advance through accept, scan and publish
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (stat.scan_done) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/ldr_datapath.sv */
module ldr_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  ldr_pkg::ldr_in_t   in_data,
  input  ldr_pkg::ldr_cmd_t  cmd,
  output ldr_pkg::ldr_stat_t stat,
  input  logic               out_stall,
  output logic               out_valid,
  output ldr_pkg::ldr_out_t  out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  logic signed [ldr_pkg::VALUE_W-1:0] value;
  logic                               last_item;
  logic [FW-1:0]                      fill;
  logic [FW-1:0]                      fill_next;
  logic [FW-1:0]                      scan_idx;
  logic                               pending;
  logic                               found;
  logic                               issue;
  logic                               full;
  logic                               store;
  logic [ldr_pkg::VALUE_W-1:0]        rd_data;

  assign full      = (fill == FW'(TABLE_DEPTH));
  assign store     = !found && !full;
  assign fill_next = fill + FW'(store);
  assign issue     = cmd.scan && !found && (scan_idx != fill);

  assign stat.scan_done = !pending && (found || (scan_idx == fill));
  assign stat.out_free  = !out_valid || !out_stall;

  // Distinct values of the current list
  ldr_ram #(
    .WIDTH (ldr_pkg::VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.publish && store),
    .wr_addr (fill[AW-1:0]),
    .wr_data (value),
    .rd_addr (scan_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  // Hold the item being worked on
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value     <= in_data.value;
      last_item <= in_data.last_item;
    end
  end

  // Walk the table, one read per cycle, compare in the cycle after each read
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      pending  <= 1'b0;
      found    <= 1'b0;
    end else if (cmd.load) begin
      scan_idx <= '0;
      pending  <= 1'b0;
      found    <= 1'b0;
    end else begin
      pending <= issue;
      if (issue) begin
        scan_idx <= scan_idx + FW'(1);
      end
      if (pending && (rd_data == value)) begin
        found <= 1'b1;
      end
    end
  end

  // Update the fill count, drop it after the list's last item
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.publish) begin
      fill <= last_item ? '0 : fill_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data.keep           <= !found;
      out_data.kept_value     <= value;
      out_data.distinct_count <= ldr_pkg::COUNT_W'(fill_next);
      out_data.overflow       <= !found && full;
      out_data.list_end       <= last_item;
    end
  end

endmodule

/* bench/tb_list_duplicate_remover_top.sv */
`timescale 1ns / 1ps

module tb_list_duplicate_remover_top;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_ITEMS = 1200;
  localparam int HOLD_AT = 300;
  localparam int DRAIN_AT = 650;
  localparam int QUIET_AT = 1050;
  localparam int LONG_HOLD_CYCLES = 200;

  typedef enum int {
    LIST_DUPS,
    LIST_FILL,
    LIST_SPILL,
    LIST_NOISE
  } list_kind_t;

  // Directed row: stimulus plus, where typed is set, the result read off by hand
  typedef struct packed {
    logic signed [ldr_pkg::VALUE_W-1:0] value;
    logic                               is_last;
    logic                               typed;
    logic                               keep;
    logic [ldr_pkg::COUNT_W-1:0]        count;
    logic                               ovf;
  } dir_row_t;

  localparam int NUM_DIRECTED = 18;
  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // fresh table after reset, zero and its repeat
    '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 7'd1, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 7'd1, 1'b0},
    // extremes of the value field
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b1, 7'd2, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 1'b1, 7'd3, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 7'd4, 1'b0},
    '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, 7'd4, 1'b0},
    // list end on a duplicate keeps the count that includes it
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 7'd4, 1'b0},
    // table must be empty again for the next list
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 7'd1, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b1, 1'b1, 7'd2, 1'b0},
    // single-item list
    '{32'h8000_0000, 1'b1, 1'b1, 1'b1, 7'd1, 1'b0},
    // alternating bit patterns, one pair a single bit apart
    '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
    '{32'h5555_5554, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0},
    '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0},
    // list of one repeated value
    '{32'h0000_0001, 1'b0, 1'b1, 1'b1, 7'd1, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b1, 1'b0, 7'd1, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b1, 1'b0, 7'd1, 1'b0}
  };

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  ldr_pkg::ldr_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  ldr_pkg::ldr_out_t out_data;

  // Shadow of the distinct-value table
  logic [ldr_pkg::VALUE_W-1:0] seen_vals [TABLE_DEPTH];
  int                          seen_fill = 0;

  ldr_pkg::ldr_out_t pending_results [$];
  int                mismatch_count = 0;
  int                items_sent = 0;
  bit                idle_bursts = 1'b1;
  bit                long_hold_req = 1'b0;

  list_duplicate_remover_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Look the value up, append it if new and there is room, clear on list end
  function automatic ldr_pkg::ldr_out_t predict_dedup(input ldr_pkg::ldr_in_t item);
    ldr_pkg::ldr_out_t res;
    bit                hit;
    hit = 1'b0;
    for (int i = 0; i < seen_fill; i++) begin
      if (seen_vals[i] == item.value) hit = 1'b1;
    end
    res.keep = !hit;
    res.kept_value = item.value;
    res.overflow = 1'b0;
    if (!hit) begin
      if (seen_fill < TABLE_DEPTH) begin
        seen_vals[seen_fill] = item.value;
        seen_fill++;
      end else begin
        res.overflow = 1'b1;
      end
    end
    res.distinct_count = ldr_pkg::COUNT_W'(seen_fill);
    res.list_end = item.last_item;
    if (item.last_item) seen_fill = 0;
    return res;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_result(input ldr_pkg::ldr_out_t got);
    ldr_pkg::ldr_out_t want;
    if (pending_results.size() == 0) begin
      note_mismatch($sformatf("result with none expected, value %0d", got.kept_value));
      return;
    end
    want = pending_results.pop_front();
    if (got.keep !== want.keep)
      note_mismatch($sformatf("keep %b, expected %b (value %0d)",
                              got.keep, want.keep, want.kept_value));
    if (got.kept_value !== want.kept_value)
      note_mismatch($sformatf("kept_value %0d, expected %0d", got.kept_value,
                              want.kept_value));
    if (got.distinct_count !== want.distinct_count)
      note_mismatch($sformatf("distinct_count %0d, expected %0d (value %0d)",
                              got.distinct_count, want.distinct_count, want.kept_value));
    if (got.overflow !== want.overflow)
      note_mismatch($sformatf("overflow %b, expected %b (value %0d)",
                              got.overflow, want.overflow, want.kept_value));
    if (got.list_end !== want.list_end)
      note_mismatch($sformatf("list_end %b, expected %b (value %0d)",
                              got.list_end, want.list_end, want.kept_value));
  endtask

  // Check each result item as it leaves the block
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result(out_data);
  end

  // Stall the output in random bursts, or for one long stretch on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
      end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item at a falling edge, hold it until taken, then maybe idle
  task automatic send_item(input ldr_pkg::ldr_in_t item, input bit typed,
                           input ldr_pkg::ldr_out_t typed_res);
    ldr_pkg::ldr_out_t predicted;
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_dedup(item);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
    @(negedge clk);
    if (idle_bursts && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic send_value(input logic [ldr_pkg::VALUE_W-1:0] value, input bit is_last);
    ldr_pkg::ldr_in_t item;
    item.value = value;
    item.last_item = is_last;
    send_item(item, 1'b0, '0);
  endtask

  // Mostly random words, with the corner values now and then
  function automatic logic [ldr_pkg::VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Short list drawn from a small pool, so repeats are common
  task automatic run_dup_list();
    logic [ldr_pkg::VALUE_W-1:0] pool [8];
    int                          n_pool;
    int                          len;
    n_pool = $urandom_range(1, 8);
    len = $urandom_range(1, 24);
    for (int i = 0; i < n_pool; i++) pool[i] = rand_value();
    for (int i = 0; i < len; i++) send_value(pool[$urandom_range(0, n_pool - 1)], i == len - 1);
  endtask

  // Long list of distinct values with repeats mixed in; with spill set it runs past
  // a full table and then revisits both stored and unstored values
  task automatic run_wide_list(input bit spill);
    logic [ldr_pkg::VALUE_W-1:0] base;
    logic [ldr_pkg::VALUE_W-1:0] stride;
    int                          n_vals;
    int                          next_new;
    int                          tail;
    base = $urandom;
    stride = $urandom | 32'd1;
    n_vals = spill ? TABLE_DEPTH + $urandom_range(1, 20) : TABLE_DEPTH;
    next_new = 0;
    while (next_new < n_vals) begin
      if (next_new > 0 && $urandom_range(0, 3) == 0) begin
        send_value(base + stride * $urandom_range(0, next_new - 1), 1'b0);
      end else begin
        send_value(base + stride * next_new, !spill && next_new == n_vals - 1);
        next_new++;
      end
    end
    if (spill) begin
      tail = $urandom_range(5, 25);
      for (int i = 0; i < tail; i++)
        send_value(base + stride * $urandom_range(0, n_vals - 1), i == tail - 1);
    end
  endtask

  // Random words with the list end flag set at random
  task automatic run_noise();
    int len;
    len = $urandom_range(1, 6);
    repeat (len) send_value($urandom, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    ldr_pkg::ldr_in_t  item;
    ldr_pkg::ldr_out_t typed_res;
    list_kind_t        kind;
    bit                hold_done;
    bit                drain_done;
    int                pick;
    hold_done = 1'b0;
    drain_done = 1'b0;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      item.value = DIRECTED_ROWS[r].value;
      item.last_item = DIRECTED_ROWS[r].is_last;
      typed_res.keep = DIRECTED_ROWS[r].keep;
      typed_res.kept_value = DIRECTED_ROWS[r].value;
      typed_res.distinct_count = DIRECTED_ROWS[r].count;
      typed_res.overflow = DIRECTED_ROWS[r].ovf;
      typed_res.list_end = DIRECTED_ROWS[r].is_last;
      send_item(item, DIRECTED_ROWS[r].typed, typed_res);
    end

    // Random lists: start with a spilling and an exactly full table
    run_wide_list(1'b1);
    run_wide_list(1'b0);
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        long_hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= DRAIN_AT) begin
        drain_done = 1'b1;
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      if (items_sent >= QUIET_AT) idle_bursts = 1'b0;
      pick = $urandom_range(0, 19);
      kind = pick < 10 ? LIST_DUPS : pick < 14 ? LIST_NOISE : pick < 17 ? LIST_FILL : LIST_SPILL;
      case (kind)
        LIST_DUPS:  run_dup_list();
        LIST_NOISE: run_noise();
        LIST_FILL:  run_wide_list(1'b0);
        default:    run_wide_list(1'b1);
      endcase
    end

    // Let everything drain, then watch for stray results
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #1_500_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ldr_pkg.sv
rtl/ldr_ram.sv
rtl/ldr_ctrl.sv
rtl/ldr_datapath.sv
rtl/list_duplicate_remover_top.sv
bench/tb_list_duplicate_remover_top.sv
